/* rtl/core/assert_macros.svh */
// Assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/rqcs_pkg.sv */
// Package with codes and types of the ready queue scheduler
`default_nettype none
package rqcs_pkg;
  localparam logic [2:0] REQ_IDLE      = 3'd0;
  localparam logic [2:0] REQ_PREEMPT   = 3'd1;
  localparam logic [2:0] REQ_YIELD     = 3'd2;
  localparam logic [2:0] REQ_TERMINATE = 3'd3;
  localparam logic [2:0] REQ_WAKE      = 3'd4;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_IDLE     = 2'd2;
  localparam logic [1:0] ACT_PREEMPT  = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_NOCPU = 2'd2;

  localparam logic [1:0] MODE_SRTF = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SLICE = 2'd1;
  localparam logic [1:0] REG_CPUS  = 2'd2;

  localparam int SLICE_W = 16;

  typedef struct packed {
    logic wr;
    logic sh;
  } cell_ctrl_t;
endpackage
`default_nettype wire

/* rtl/core/ready_queue_cpu_scheduler_top.sv */
// Top level of the ready queue scheduler: sequencer, processor records, slot chain
// Sequence: wake-up and rejected events go from S_EVAL straight to the result strobe;
//   pick events pass through S_EVAL and then S_SCAN, which in SRTF mode scans each queued entry.
// Throughput: one request at a time; busy_o stays high until the result is out.
// The SRTF minimum search walks the slot chain one entry a cycle.
// Reset: asynchronous, active low; queue empty, all processors idle, registers at defaults.
`default_nettype none
module ready_queue_cpu_scheduler_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_CPUS    = 4,
  parameter int PID_BITS    = 8,
  parameter int TIME_BITS   = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [2:0]            req_type_i,
  input  wire logic [1:0]            cpu_index_i,
  input  wire logic [PID_BITS-1:0]   process_id_i,
  input  wire logic [TIME_BITS-1:0]  time_left_i,
  output logic                       result_valid_o,
  output logic      [1:0]            action_o,
  output logic      [1:0]            target_cpu_o,
  output logic      [PID_BITS-1:0]   chosen_process_o,
  output logic      [15:0]           slice_out_o,
  output logic      [1:0]            error_code_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);
  localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int NW = 5;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] mode_q;
  logic [15:0] slice_q;
  logic [2:0] cpus_q;

  logic [2:0] req_q;
  logic [1:0] idx_q;
  logic [PID_BITS-1:0] pid_q;
  logic [TIME_BITS-1:0] t_q;

  logic [QW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] k_q, k_d;
  logic [IW-1:0] sel_q, sel_d;
  logic [TIME_BITS-1:0] best_q, best_d;
  logic [1:0] err_q, err_d;

  logic [MAX_CPUS-1:0] cbusy_q, cbusy_d;
  logic [PID_BITS-1:0] cpid_q [MAX_CPUS];
  logic [TIME_BITS-1:0] ctime_q [MAX_CPUS];
  logic cwr;
  logic [PID_BITS-1:0] cwr_pid;
  logic [TIME_BITS-1:0] cwr_time;

  logic ov_q, ov_d;
  logic [1:0] act_q, act_d, tgt_q, tgt_d, oerr_q, oerr_d;
  logic [PID_BITS-1:0] ch_q, ch_d;
  logic [15:0] osl_q, osl_d;

  rqcs_pkg::cell_ctrl_t ctrl [QUEUE_DEPTH];
  logic [PID_BITS-1:0] qpid [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] qtime [QUEUE_DEPTH];
  logic [PID_BITS-1:0] wr_pid;
  logic [TIME_BITS-1:0] wr_time;
  logic enq;
  logic shift;

  logic [NW-1:0] n_act;
  logic [CW-1:0] cidx;
  logic full;
  logic any_idle;
  logic [CW-1:0] wbest;
  logic [TIME_BITS-1:0] wbest_t;
  logic accept;
  logic cfg_wr;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      rqcs_pkg::REG_MODE:  prdata = {30'd0, mode_q};
      rqcs_pkg::REG_SLICE: prdata = {16'd0, slice_q};
      rqcs_pkg::REG_CPUS:  prdata = {29'd0, cpus_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (cpus_q == 3'd0) begin
      n_act = NW'(1);
    end else if ({2'd0, cpus_q} > NW'(MAX_CPUS)) begin
      n_act = NW'(MAX_CPUS);
    end else begin
      n_act = {2'd0, cpus_q};
    end
  end

  assign cidx = CW'(idx_q);
  assign full = (cnt_q == QW'(QUEUE_DEPTH));

  always_comb begin
    any_idle = 1'b0;
    wbest    = '0;
    wbest_t  = '0;
    for (int i = 0; i < MAX_CPUS; i++) begin
      if ((NW'(i) < n_act) && !any_idle) begin
        if (!cbusy_q[i]) begin
          any_idle = 1'b1;
        end else if (ctime_q[i] > wbest_t) begin
          wbest   = CW'(i);
          wbest_t = ctime_q[i];
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    sel_d    = sel_q;
    best_d   = best_q;
    err_d    = err_q;
    cbusy_d  = cbusy_q;
    cwr      = 1'b0;
    cwr_pid  = qpid[sel_q];
    cwr_time = best_q;
    ov_d     = 1'b0;
    act_d    = act_q;
    tgt_d    = tgt_q;
    oerr_d   = oerr_q;
    ch_d     = ch_q;
    osl_d    = osl_q;
    enq      = 1'b0;
    shift    = 1'b0;
    wr_pid   = pid_q;
    wr_time  = t_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        act_d  = rqcs_pkg::ACT_NONE;
        tgt_d  = 2'd0;
        ch_d   = '0;
        osl_d  = '0;
        oerr_d = rqcs_pkg::ERR_OK;
        if (req_q == rqcs_pkg::REQ_WAKE) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
          if (full) begin
            oerr_d = rqcs_pkg::ERR_FULL;
          end else begin
            enq = 1'b1;
            cnt_d = cnt_q + QW'(1);
            if (mode_q == rqcs_pkg::MODE_SRTF && !any_idle && wbest_t > t_q) begin
              act_d = rqcs_pkg::ACT_PREEMPT;
              tgt_d = 2'(wbest);
            end
          end
        end else if (req_q > rqcs_pkg::REQ_WAKE) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end else if ({3'd0, idx_q} >= n_act) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
          tgt_d   = idx_q;
          oerr_d  = rqcs_pkg::ERR_NOCPU;
        end else begin
          err_d  = rqcs_pkg::ERR_OK;
          best_d = qtime[0];
          if (req_q != rqcs_pkg::REQ_IDLE) begin
            if (!cbusy_q[cidx]) begin
              err_d = rqcs_pkg::ERR_NOCPU;
            end else if (req_q == rqcs_pkg::REQ_PREEMPT) begin
              if (full) begin
                err_d = rqcs_pkg::ERR_FULL;
              end else begin
                enq     = 1'b1;
                wr_pid  = cpid_q[cidx];
                cnt_d   = cnt_q + QW'(1);
                if (cnt_q == '0) begin
                  best_d = t_q;
                end
              end
            end
          end
          k_d     = QW'(1);
          sel_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mode_q == rqcs_pkg::MODE_SRTF && k_q < cnt_q) begin
          if (qtime[k_q[IW-1:0]] < best_q) begin
            sel_d  = k_q[IW-1:0];
            best_d = qtime[k_q[IW-1:0]];
          end
          k_d = k_q + QW'(1);
        end else begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
          tgt_d   = idx_q;
          oerr_d  = err_q;
          if (cnt_q == '0) begin
            act_d          = rqcs_pkg::ACT_IDLE;
            cbusy_d[cidx]  = 1'b0;
          end else begin
            act_d         = rqcs_pkg::ACT_DISPATCH;
            ch_d          = qpid[sel_q];
            osl_d         = slice_q;
            cbusy_d[cidx] = 1'b1;
            cwr           = 1'b1;
            shift         = 1'b1;
            cnt_d         = cnt_q - QW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    logic [PID_BITS-1:0]  nb_pid;
    logic [TIME_BITS-1:0] nb_time;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nb_pid  = qpid[g];
      assign nb_time = qtime[g];
    end else begin : g_mid
      assign nb_pid  = qpid[g+1];
      assign nb_time = qtime[g+1];
    end
    assign ctrl[g].wr = enq && (cnt_q == QW'(g));
    assign ctrl[g].sh = shift && (IW'(g) >= sel_q) && (QW'(g + 1) < cnt_q);
    rqcs_cell #(
      .PID_BITS (PID_BITS),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[g]),
      .wr_pid_i (wr_pid),
      .wr_time_i(wr_time),
      .nb_pid_i (nb_pid),
      .nb_time_i(nb_time),
      .pid_o    (qpid[g]),
      .time_o   (qtime[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= '0;
      slice_q <= '0;
      cpus_q  <= 3'd1;
      cnt_q   <= '0;
      cbusy_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cbusy_q <= cbusy_d;
      ov_q    <= ov_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          rqcs_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
          rqcs_pkg::REG_SLICE: slice_q <= pwdata[15:0];
          rqcs_pkg::REG_CPUS:  cpus_q  <= pwdata[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      idx_q <= cpu_index_i;
      pid_q <= process_id_i;
      t_q   <= time_left_i;
    end
    k_q    <= k_d;
    sel_q  <= sel_d;
    best_q <= best_d;
    err_q  <= err_d;
    act_q  <= act_d;
    tgt_q  <= tgt_d;
    oerr_q <= oerr_d;
    ch_q   <= ch_d;
    osl_q  <= osl_d;
    if (cwr) begin
      cpid_q[cidx]  <= cwr_pid;
      ctime_q[cidx] <= cwr_time;
    end
  end

  assign result_valid_o   = ov_q;
  assign action_o         = act_q;
  assign target_cpu_o     = tgt_q;
  assign chosen_process_o = ch_q;
  assign slice_out_o      = osl_q;
  assign error_code_o     = oerr_q;
endmodule
`default_nettype wire

/* rtl/core/rqcs_cell.sv */
// One ready queue slot: loads a new entry or takes its neighbor's entry
`default_nettype none
module rqcs_cell #(
  parameter int PID_BITS  = 8,
  parameter int TIME_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire rqcs_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [PID_BITS-1:0]   wr_pid_i,
  input  wire logic [TIME_BITS-1:0]  wr_time_i,
  input  wire logic [PID_BITS-1:0]   nb_pid_i,
  input  wire logic [TIME_BITS-1:0]  nb_time_i,
  output logic      [PID_BITS-1:0]   pid_o,
  output logic      [TIME_BITS-1:0]  time_o
);
  logic [PID_BITS-1:0]  pid_q;
  logic [TIME_BITS-1:0] time_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      pid_q  <= wr_pid_i;
      time_q <= wr_time_i;
    end else if (ctrl_i.sh) begin
      pid_q  <= nb_pid_i;
      time_q <= nb_time_i;
    end
  end

  assign pid_o  = pid_q;
  assign time_o = time_q;
endmodule
`default_nettype wire

/* rtl/core/rqcs_checker.sv */
// Port checker for the ready queue scheduler, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module rqcs_checker #(
  parameter int PID_BITS = 8
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                result_valid_o,
  input wire logic [1:0]          action_o,
  input wire logic [PID_BITS-1:0] chosen_process_o,
  input wire logic [15:0]         slice_out_o,
  input wire logic [1:0]          error_code_o
);
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `ASSERT_IMPL(a_strobe_released, clk_i, rst_ni, result_valid_o, !busy_o)
  `ASSERT_IMPL(a_no_dispatch_zero, clk_i, rst_ni,
    result_valid_o && (action_o != rqcs_pkg::ACT_DISPATCH),
    (chosen_process_o == '0) && (slice_out_o == '0))
  `ASSERT_IMPL(a_err_code, clk_i, rst_ni, result_valid_o, error_code_o != 2'd3)
endmodule

bind ready_queue_cpu_scheduler_top rqcs_checker #(
  .PID_BITS(PID_BITS)
) u_rqcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .result_valid_o  (result_valid_o),
  .action_o        (action_o),
  .chosen_process_o(chosen_process_o),
  .slice_out_o     (slice_out_o),
  .error_code_o    (error_code_o)
);
`default_nettype wire
